// ----- hdl/sfbl_pkg.sv -----
package sfbl_pkg;

    // default table depth
    localparam int ENTRIES_DEF = 16;

    // action codes
    localparam logic [2:0] ACT_PUSH   = 3'd0;
    localparam logic [2:0] ACT_INSERT = 3'd1;
    localparam logic [2:0] ACT_REMOVE = 3'd2;
    localparam logic [2:0] ACT_QUERY  = 3'd3;
    localparam logic [2:0] ACT_POP    = 3'd4;

    // status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;
    localparam logic [1:0] ST_EMPTY     = 2'd3;

    // one stored descriptor, as seen by the neighbor cells
    typedef struct packed {
        logic        valid;
        logic [31:0] addr;
        logic [31:0] size;
    } t_ent;

    // scan token handed down the chain: any hit upstream, and the first hit's data
    typedef struct packed {
        logic        seen;
        logic [31:0] addr;
        logic [31:0] size;
    } t_scan;

    // command broadcast to every cell
    typedef struct packed {
        logic [2:0]  act;
        logic [31:0] addr;
        logic [31:0] size;
        logic        apply;
        logic        open_gap;
        logic        close_gap;
    } t_cmd;

endpackage

// ----- hdl/sfbl_cell.sv -----
module sfbl_cell (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  sfbl_pkg::t_cmd   i_cmd,
    input  sfbl_pkg::t_ent   i_left,
    input  sfbl_pkg::t_ent   i_right,
    output sfbl_pkg::t_ent   o_ent,
    input  sfbl_pkg::t_scan  i_scan,
    output sfbl_pkg::t_scan  o_scan
);
    import sfbl_pkg::*;

    t_ent  r_ent;
    t_ent  n_ent;
    t_scan r_scan;
    logic  w_hit;

    // local match for the current action
    always_comb begin
        case (i_cmd.act)
            ACT_PUSH:   w_hit = 1'b1;
            ACT_INSERT: w_hit = !r_ent.valid || (i_cmd.addr < r_ent.addr);
            ACT_REMOVE: w_hit = r_ent.valid && (i_cmd.addr == r_ent.addr);
            ACT_QUERY:  w_hit = r_ent.valid && (r_ent.size > i_cmd.size);
            ACT_POP:    w_hit = r_ent.valid;
            default:    w_hit = 1'b0;
        endcase
    end

    // token to the next cell: first hit wins
    always_comb begin
        o_scan.seen = r_scan.seen | w_hit;
        o_scan.addr = r_scan.seen ? r_scan.addr : r_ent.addr;
        o_scan.size = r_scan.seen ? r_scan.size : r_ent.size;
    end

    // open: past 1st hit shift right, it loads entry; close: from it shift left
    always_comb begin
        n_ent = r_ent;
        if (i_cmd.apply) begin
            if (i_cmd.open_gap) begin
                if (r_scan.seen) begin
                    n_ent = i_left;
                end else if (w_hit) begin
                    n_ent = '{valid: 1'b1, addr: i_cmd.addr, size: i_cmd.size};
                end
            end else if (i_cmd.close_gap) begin
                if (r_scan.seen || w_hit) begin
                    n_ent = i_right;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_ent.addr  <= n_ent.addr;
        r_ent.size  <= n_ent.size;
        r_scan.addr <= i_scan.addr;
        r_scan.size <= i_scan.size;
        if (!i_rst_n) begin
            r_ent.valid <= 1'b0;
            r_scan.seen <= 1'b0;
        end else begin
            r_ent.valid <= n_ent.valid;
            r_scan.seen <= i_scan.seen;
        end
    end

    assign o_ent = r_ent;

endmodule

// ----- hdl/sorted_free_block_list.sv -----
// Channel   Direction  Handshake          Fields
// command   in         start / busy       i_action, i_in_address, i_in_size
// result    out        o_done (1 cycle)   o_status, o_out_address, o_out_size
//
// A transaction is taken when start is high and busy is low.
// The block passes through the sweep and apply states before the result strobe and stays busy
// meanwhile, one transaction at a time: the hit token ripples one cell per cycle down the chain.
// Synchronous active-low reset empties the table (valid bits cleared) and idles the block.
// The receiver cannot stall: o_done is high for one cycle only; the result fields hold until the next apply.
module sorted_free_block_list #(
    parameter int ENTRIES = sfbl_pkg::ENTRIES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  i_action,
    input  logic [31:0] i_in_address,
    input  logic [31:0] i_in_size,
    output logic        o_done,
    output logic [1:0]  o_status,
    output logic [31:0] o_out_address,
    output logic [31:0] o_out_size
);
    import sfbl_pkg::*;

    localparam int CW = (ENTRIES > 2) ? $clog2(ENTRIES - 1) : 1;
    localparam logic [CW-1:0] SWEEP_LAST = CW'(ENTRIES - 2);

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_SWEEP = 3'b010,
        S_APPLY = 3'b100
    } t_state;

    t_state        r_state;
    logic [CW-1:0] r_cnt;
    logic [2:0]    r_act;
    logic [31:0]   r_addr;
    logic [31:0]   r_size;
    logic          r_done;
    logic [1:0]    r_status;
    logic [31:0]   r_oaddr;
    logic [31:0]   r_osize;
    logic [1:0]    n_status;
    logic [31:0]   n_oaddr;
    logic [31:0]   n_osize;

    t_cmd              w_cmd;
    t_ent              w_ent   [ENTRIES];
    t_ent              w_left  [ENTRIES];
    t_ent              w_right [ENTRIES];
    t_scan             w_scan  [ENTRIES+1];
    logic [ENTRIES-1:0] w_valid;
    logic              w_full;
    logic              w_found;

    // cell chain
    assign w_scan[0] = '0;
    genvar gi;
    generate
        for (gi = 0; gi < ENTRIES; gi++) begin : g_cell
            if (gi == 0) begin : g_head
                assign w_left[gi] = '0;
            end else begin : g_mid_l
                assign w_left[gi] = w_ent[gi-1];
            end
            if (gi == ENTRIES - 1) begin : g_tail
                assign w_right[gi] = '0;
            end else begin : g_mid_r
                assign w_right[gi] = w_ent[gi+1];
            end
            assign w_valid[gi] = w_ent[gi].valid;

            sfbl_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_cmd   (w_cmd),
                .i_left  (w_left[gi]),
                .i_right (w_right[gi]),
                .o_ent   (w_ent[gi]),
                .i_scan  (w_scan[gi]),
                .o_scan  (w_scan[gi+1])
            );
        end
    endgenerate

    assign w_full  = w_ent[ENTRIES-1].valid;
    assign w_found = w_scan[ENTRIES].seen;

    // broadcast command
    always_comb begin
        w_cmd.act       = r_act;
        w_cmd.addr      = r_addr;
        w_cmd.size      = r_size;
        w_cmd.apply     = (r_state == S_APPLY);
        w_cmd.open_gap  = ((r_act == ACT_PUSH) || (r_act == ACT_INSERT)) && !w_full;
        w_cmd.close_gap = (r_act == ACT_REMOVE) || (r_act == ACT_POP);
    end

    // result of the transaction
    always_comb begin
        n_status = ST_OK;
        n_oaddr  = '0;
        n_osize  = '0;
        case (r_act)
            ACT_PUSH, ACT_INSERT: begin
                n_status = w_full ? ST_FULL : ST_OK;
            end
            ACT_REMOVE: begin
                n_status = w_found ? ST_OK : ST_NOT_FOUND;
            end
            ACT_QUERY: begin
                n_status = w_found ? ST_OK : ST_NOT_FOUND;
                n_oaddr  = w_found ? w_scan[ENTRIES].addr : '0;
                n_osize  = w_found ? w_scan[ENTRIES].size : '0;
            end
            ACT_POP: begin
                n_status = w_found ? ST_OK : ST_EMPTY;
                n_oaddr  = w_found ? w_scan[ENTRIES].addr : '0;
                n_osize  = w_found ? w_scan[ENTRIES].size : '0;
            end
            default: begin
                n_status = ST_OK;
            end
        endcase
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_state <= S_SWEEP;
                        r_cnt   <= SWEEP_LAST;
                    end
                end
                S_SWEEP: begin
                    if (r_cnt == '0) begin
                        r_state <= S_APPLY;
                    end else begin
                        r_cnt <= r_cnt - 1'b1;
                    end
                end
                S_APPLY: begin
                    r_state <= S_IDLE;
                    r_done  <= 1'b1;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // command and result payload
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && start) begin
            r_act  <= i_action;
            r_addr <= i_in_address;
            r_size <= i_in_size;
        end
        if (r_state == S_APPLY) begin
            r_status <= n_status;
            r_oaddr  <= n_oaddr;
            r_osize  <= n_osize;
        end
    end

    assign busy          = (r_state != S_IDLE);
    assign o_done        = r_done;
    assign o_status      = r_status;
    assign o_out_address = r_oaddr;
    assign o_out_size    = r_osize;

    // valid entries always form a prefix of the chain
    a_valid_prefix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_valid & (w_valid + 1'b1)) == '0)
        else $error("valid entries not contiguous from the head");

    a_done_after_apply: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(r_state == S_APPLY))
        else $error("result strobe without an apply cycle");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (busy && !o_done))
        else $error("accepted transaction did not raise busy");

    a_full_stays: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_status == ST_FULL) |-> w_full)
        else $error("full status but table not full");

    a_empty_stays: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_status == ST_EMPTY) |-> !w_valid[0])
        else $error("empty status but table holds entries");

endmodule
